[rtl/fnv_pkg.sv]
`timescale 1ns / 1ps

package fnv_pkg;

  localparam int HashW    = 64;
  localparam int HalfW    = 32;
  localparam int WidthW   = 7;
  localparam int ByteW    = 8;
  localparam int CfgAddrW = 2;
  localparam int ModeW    = 2;

  typedef logic [HashW-1:0]  hash_t;
  typedef logic [WidthW-1:0] width_t;

  // standard offset bases
  localparam hash_t             Basis64 = 64'hCBF2_9CE4_8422_2325;
  localparam logic [HalfW-1:0]  Basis32 = 32'h811C_9DC5;

  // hash mode codes; code 3 behaves as the zero-basis mode
  localparam logic [ModeW-1:0] MODE_FNV1A = 2'd0;
  localparam logic [ModeW-1:0] MODE_FNV1  = 2'd1;
  localparam logic [ModeW-1:0] MODE_FNV0  = 2'd2;

  typedef enum logic [CfgAddrW-1:0] {
    REG_HASH_MODE    = 2'd0,
    REG_USE_CUSTOM   = 2'd1,
    REG_CUSTOM_BASIS = 2'd2,
    REG_OUT_BITS     = 2'd3
  } cfg_reg_t;

  // controls for the final fold
  typedef struct packed {
    logic   wide;  // 64-bit hash in use
    width_t tw;    // target width, 1..64
  } fold_cfg_t;

  // out_bits with 0 read as 1 and anything above 64 read as 64
  function automatic width_t target_width(input width_t ob);
    width_t tw;
    if (ob == '0) begin
      tw = width_t'(1);
    end else if (ob > width_t'(HashW)) begin
      tw = width_t'(HashW);
    end else begin
      tw = ob;
    end
    return tw;
  endfunction

endpackage

[rtl/fnv_fold.sv]
`timescale 1ns / 1ps

module fnv_fold (
  input  fnv_pkg::hash_t     hash_i,
  input  fnv_pkg::fold_cfg_t cfg_i,
  output fnv_pkg::hash_t     fold_o
);
  import fnv_pkg::*;

  localparam int Steps = 6;  // halvings from 64 down to 1

  always_comb begin
    hash_t  h;
    width_t wbits;
    width_t cur;
    width_t b;
    h     = hash_i;
    wbits = cfg_i.wide ? width_t'(HashW) : width_t'(HalfW);
    cur   = wbits;
    // halve while the half still covers the target width
    for (int k = 0; k < Steps; k++) begin
      b = width_t'(HalfW >> k);
      if ((b < wbits) && (b >= cfg_i.tw)) begin
        h   = (h ^ (h >> (HalfW >> k))) & ((hash_t'(1) << (HalfW >> k)) - hash_t'(1));
        cur = b;
      end
    end
    // target width not a power of two: one last fold at the exact width
    if (cur > cfg_i.tw) begin
      h = (h ^ (h >> cfg_i.tw)) & ((hash_t'(1) << cfg_i.tw[5:0]) - hash_t'(1));
    end
    fold_o = h;
  end

endmodule

[rtl/fnv_hash_xor_fold.sv]
`timescale 1ns / 1ps
// Path: the byte that carries in_tlast passes the input register, then the
//   finished-hash register, then the result register, where out_tvalid rises.
// Throughput: one input transfer per cycle until a stalled output fills the pipe;
//   each byte's constant-prime multiply is shift-add logic done within the cycle.
// Reset: synchronous, active low; clears the pipeline, ends any open message
//   and returns all configuration registers to their reset values.

module fnv_hash_xor_fold (
  input  logic                   clk,
  input  logic                   rst_n,

  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] byte_present
  input  logic                   in_tlast,   // last_byte

  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output fnv_pkg::hash_t         out_tdata,  // [63:0] hash_value

  // configuration write port
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [63:0]            cfg_wdata
);
  import fnv_pkg::*;

  // configuration registers
  logic [ModeW-1:0] hash_mode_r;
  logic             use_custom_r;
  hash_t            custom_basis_r;
  width_t           out_bits_r;

  // stage A: input register
  logic             a_valid_r;
  logic [ByteW-1:0] a_byte_r;
  logic             a_present_r;
  logic             a_last_r;

  // message state
  hash_t            run_r;
  hash_t            run_nxt;
  logic             in_msg_r;
  logic             in_msg_nxt;

  // stage B: finished hash waiting for the fold
  logic             fin_valid_r;
  hash_t            fin_hash_r;

  // stage C: result register
  logic             out_tvalid_r;
  hash_t            out_tdata_r;

  logic             out_free;
  logic             fin_free;
  logic             a_go;
  logic             a_active;
  fold_cfg_t        fold_cfg;
  hash_t            folded;

  // x * 0x00000100000001B3 mod 2^64
  function automatic hash_t mul_prime64(input hash_t x);
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // x * 0x01000193 mod 2^32
  function automatic logic [HalfW-1:0] mul_prime32(input logic [HalfW-1:0] x);
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

  // ---------------------------------------------------------------------------
  // Flow control: each stage moves when the one after it is empty or moving.
  // Stage A holds every item, so in_tready depends on out_tready through the
  // chain but the three registers let input keep flowing while a result waits.
  // ---------------------------------------------------------------------------
  assign out_free  = !out_tvalid_r || out_tready;
  assign fin_free  = !fin_valid_r || out_free;
  assign a_go      = a_valid_r && fin_free;
  assign in_tready = !a_valid_r || a_go;
  assign a_active  = a_go && (a_present_r || a_last_r);  // idle items change nothing

  // width of the hash follows the target width: narrow for 32 bits or less
  assign fold_cfg.tw   = target_width(out_bits_r);
  assign fold_cfg.wide = fold_cfg.tw > width_t'(HalfW);

  // ---------------------------------------------------------------------------
  // Hash update for the item in stage A
  // ---------------------------------------------------------------------------
  always_comb begin
    hash_t basis;
    hash_t h0;
    hash_t mul_in;
    hash_t prod;
    hash_t byte_ext;

    byte_ext = hash_t'(a_byte_r);

    // starting value for a new message
    if (hash_mode_r >= MODE_FNV0) begin
      basis = '0;
    end else if (use_custom_r) begin
      basis = custom_basis_r;
    end else if (fold_cfg.wide) begin
      basis = Basis64;
    end else begin
      basis = hash_t'(Basis32);
    end
    if (!fold_cfg.wide) begin
      basis[HashW-1:HalfW] = '0;
    end

    // running value, cut to 32 bits whenever the narrow hash applies
    h0 = in_msg_r ? run_r : basis;
    if (!fold_cfg.wide) begin
      h0[HashW-1:HalfW] = '0;
    end

    // FNV-1a xors before the multiply, the others after
    mul_in = (hash_mode_r == MODE_FNV1A) ? (h0 ^ byte_ext) : h0;
    if (fold_cfg.wide) begin
      prod = mul_prime64(mul_in);
    end else begin
      prod = hash_t'(mul_prime32(mul_in[HalfW-1:0]));
    end

    if (!a_present_r) begin
      run_nxt = h0;
    end else if (hash_mode_r == MODE_FNV1A) begin
      run_nxt = prod;
    end else begin
      run_nxt = prod ^ byte_ext;
    end

    in_msg_nxt = !a_last_r;
  end

  // xor-fold of the finished hash
  fnv_fold u_fold (
    .hash_i (fin_hash_r),
    .cfg_i  (fold_cfg),
    .fold_o (folded)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_mode_r    <= MODE_FNV1A;
      use_custom_r   <= 1'b0;
      custom_basis_r <= '0;
      out_bits_r     <= width_t'(HashW);
      a_valid_r      <= 1'b0;
      in_msg_r       <= 1'b0;
      run_r          <= Basis64;
      fin_valid_r    <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_HASH_MODE:    hash_mode_r    <= cfg_wdata[ModeW-1:0];
          REG_USE_CUSTOM:   use_custom_r   <= cfg_wdata[0];
          REG_CUSTOM_BASIS: custom_basis_r <= cfg_wdata;
          REG_OUT_BITS:     out_bits_r     <= cfg_wdata[WidthW-1:0];
          default: ;
        endcase
      end

      if (in_tready) begin
        a_valid_r <= in_tvalid;
      end

      if (a_active) begin
        run_r    <= run_nxt;
        in_msg_r <= in_msg_nxt;
      end

      // stage B empties into the result register, refills on a message end
      if (fin_valid_r && out_free) begin
        fin_valid_r <= 1'b0;
      end
      if (a_active && a_last_r) begin
        fin_valid_r <= 1'b1;
      end

      if (out_free) begin
        out_tvalid_r <= fin_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      a_byte_r    <= in_tdata;
      a_present_r <= in_tuser;
      a_last_r    <= in_tlast;
    end
    if (a_active && a_last_r) begin
      fin_hash_r <= run_nxt;
    end
    if (out_free) begin
      out_tdata_r <= folded;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import fnv_pkg::*;

  // ---------------------------------------------------------------------------
  // Timing knobs
  // ---------------------------------------------------------------------------
  localparam int ResetCycles   = 9;
  localparam int SettleCycles  = 8;    // pipeline is 3 deep; a little margin
  localparam int HoldCycles    = 200;  // long receiver hold-off
  localparam int WatchdogLimit = 2000; // cycles with no transfer at all

  // FNV constants, kept here so the digest model stands on its own
  localparam hash_t Prime64    = 64'h0000_0100_0000_01B3;
  localparam hash_t Prime32    = 64'h0000_0000_0100_0193;
  localparam hash_t OffBasis64 = 64'hCBF2_9CE4_8422_2325;
  localparam hash_t OffBasis32 = 64'h0000_0000_811C_9DC5;

  // spare mode code, behaves like the zero-basis mode
  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;    // [7:0] data_byte
  logic        in_tuser   = 1'b0;  // [0] byte_present
  logic        in_tlast   = 1'b0;  // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  hash_t       out_tdata;          // [63:0] hash_value
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = '0;
  logic [63:0] cfg_wdata  = '0;

  fnv_hash_xor_fold dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Digest model: own copy of registers and hash state
  // ---------------------------------------------------------------------------
  logic [ModeW-1:0]  dig_mode;
  logic              dig_custom_en;
  hash_t             dig_basis;
  logic [WidthW-1:0] dig_out_bits;
  hash_t             dig_hash;
  logic              dig_open;      // a message has started

  hash_t digest_q[$];               // folded hashes still to arrive

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int mismatches   = 0;
  int hold_asked   = 0;
  int hold_served  = 0;
  logic hold_on    = 1'b0;
  hash_t want_hash;

  function automatic hash_t low_ones(input int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // out_bits as the block sees it: 0 -> 1, above 64 -> 64
  function automatic int fold_target();
    if (dig_out_bits == '0) return 1;
    if (dig_out_bits > 7'd64) return 64;
    return int'(dig_out_bits);
  endfunction

  // halve while the half still covers the target, then one last partial fold
  function automatic hash_t xor_fold(input hash_t h, input int w, input int t);
    int    bits;
    hash_t v;
    bits = w;
    v    = h & low_ones(w);
    if (t >= w) return v;
    while ((bits >> 1) >= t) begin
      bits = bits >> 1;
      v    = (v ^ (v >> bits)) & low_ones(bits);
    end
    if (bits > t) v = (v ^ (v >> t)) & low_ones(t);
    return v;
  endfunction

  function automatic void reset_digest();
    dig_mode      = MODE_FNV1A;
    dig_custom_en = 1'b0;
    dig_basis     = '0;
    dig_out_bits  = 7'd64;
    dig_hash      = OffBasis64;
    dig_open      = 1'b0;
  endfunction

  // one accepted input transfer; emit says a folded hash comes out of it
  function automatic void absorb_byte(input logic [7:0] d, input bit pres, input bit last,
                                      output bit emit, output hash_t folded);
    int    tw;
    int    hw;
    hash_t mask;
    hash_t prime;
    emit   = 1'b0;
    folded = '0;
    tw     = fold_target();
    hw     = (tw <= 32) ? 32 : 64;
    mask   = low_ones(hw);
    prime  = (hw == 32) ? Prime32 : Prime64;
    if (!pres && !last) return;     // idle step
    if (!dig_open) begin
      if (dig_mode >= MODE_FNV0)  dig_hash = '0;
      else if (dig_custom_en)     dig_hash = dig_basis;
      else                        dig_hash = (hw == 32) ? OffBasis32 : OffBasis64;
      dig_open = 1'b1;
    end
    // narrow width cuts the running hash on every step, even mid-message
    dig_hash = dig_hash & mask;
    if (pres) begin
      if (dig_mode == MODE_FNV1A) dig_hash = ((dig_hash ^ {56'd0, d}) * prime) & mask;
      else                        dig_hash = ((dig_hash * prime) ^ {56'd0, d}) & mask;
    end
    if (last) begin
      folded   = xor_fold(dig_hash, hw, tw);
      emit     = 1'b1;
      dig_open = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch report
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input hash_t got, input hash_t want);
    $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_on) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // hold-off counter lives in its own process
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_on <= 1'b0;
        hold_served++;
      end
    end
  end

  // result checker: every out transfer against the oldest digest
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        flag_mismatch("unexpected result", out_tdata, '0);
      end else begin
        want_hash = digest_q.pop_front();
        if (out_tdata !== want_hash) flag_mismatch("hash_value", out_tdata, want_hash);
      end
    end
  end

  // watchdog: too long without any transfer ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WatchdogLimit);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // one input transfer, with a random gap in front of it
  task automatic send_step(input logic [7:0] d, input bit pres, input bit last);
    bit    emit;
    hash_t folded;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= pres;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_byte(d, pres, last, emit, folded);
    if (emit) digest_q.push_back(folded);
  endtask

  // stop offering, let every result out, then let the pipe empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // write all four registers back to back while idle;
  // junk puts random bits above each narrow field
  task automatic configure(input logic [ModeW-1:0] mode, input bit cust, input hash_t basis,
                           input logic [WidthW-1:0] ob, input bit junk);
    logic [63:0] fill;
    drain();
    fill = junk ? {$urandom, $urandom} : '0;
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_HASH_MODE;
    cfg_wdata <= (fill & ~64'h3) | {62'd0, mode};
    @(posedge clk);
    cfg_addr  <= REG_USE_CUSTOM;
    cfg_wdata <= (fill & ~64'h1) | {63'd0, cust};
    @(posedge clk);
    cfg_addr  <= REG_CUSTOM_BASIS;
    cfg_wdata <= basis;
    @(posedge clk);
    cfg_addr  <= REG_OUT_BITS;
    cfg_wdata <= (fill & ~64'h7F) | {57'd0, ob};
    @(posedge clk);
    cfg_we    <= 1'b0;
    dig_mode      = mode;
    dig_custom_en = cust;
    dig_basis     = basis;
    dig_out_bits  = ob;
  endtask

  // a message of len bytes; with end_alone the end comes as a byte-less step.
  // returns the number of non-idle steps sent
  task automatic send_message(input int len, input bit end_alone, input bit noise,
                              output int steps);
    steps = 0;
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(9) == 0) send_step(8'($urandom), 1'b0, 1'b0);
      send_step(8'($urandom), 1'b1, (i == len - 1) && !end_alone);
      steps++;
    end
    if (len == 0 || end_alone) begin
      send_step(8'($urandom), 1'b0, 1'b1);
      steps++;
    end
  endtask

  task automatic configure_random();
    logic [WidthW-1:0] ob;
    case ($urandom_range(9))
      0:       ob = 7'd0;
      1:       ob = 7'd1;
      2:       ob = 7'd32;
      3:       ob = 7'd33;
      4:       ob = 7'd64;
      5:       ob = 7'($urandom_range(127, 65));
      6, 7:    ob = 7'($urandom_range(31, 2));
      default: ob = 7'($urandom_range(63, 34));
    endcase
    configure(2'($urandom_range(3)), 1'($urandom), {$urandom, $urandom}, ob, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset settings: empty message, extreme bytes, idle step, byte-less end
  task automatic test_reset_defaults();
    send_step(8'h00, 1'b0, 1'b1);   // empty message -> folded basis
    send_step(8'h00, 1'b1, 1'b1);   // byte and end together
    send_step(8'hFF, 1'b1, 1'b0);
    send_step(8'h3C, 1'b0, 1'b0);   // idle step, changes nothing
    send_step(8'hA5, 1'b0, 1'b1);   // end without a byte
  endtask

  // FNV-1, FNV-0 and the spare code, custom basis on and off, custom ignored in zero-basis
  task automatic test_modes();
    configure(MODE_FNV1, 1'b1, '1, 7'd64, 1'b0);
    send_step(8'h61, 1'b1, 1'b0);
    send_step(8'hFF, 1'b1, 1'b1);
    configure(MODE_SPARE, 1'b1, 64'h0123_4567_89AB_CDEF, 7'd32, 1'b0);
    send_step(8'h80, 1'b1, 1'b1);
    send_step(8'h00, 1'b0, 1'b1);
    configure(MODE_FNV0, 1'b0, '0, 7'd1, 1'b0);
    send_step(8'h01, 1'b1, 1'b0);
    send_step(8'hFE, 1'b1, 1'b1);
  endtask

  // width edges: 0 reads as 1, above 64 reads as 64, both sides of 32
  task automatic test_widths();
    configure(MODE_FNV1A, 1'b1, 64'hFFFF_FFFF_0000_0001, 7'd0, 1'b0);
    send_step(8'h55, 1'b1, 1'b1);
    configure(MODE_FNV1A, 1'b0, '0, 7'd127, 1'b0);
    send_step(8'hAA, 1'b1, 1'b1);
    configure(MODE_FNV1, 1'b0, '0, 7'd33, 1'b0);
    send_step(8'h7F, 1'b1, 1'b1);
    configure(MODE_FNV1A, 1'b1, 64'h8000_0000_FFFF_FFFF, 7'd31, 1'b0);
    send_step(8'h12, 1'b1, 1'b1);
    configure(MODE_FNV1, 1'b0, '0, 7'd16, 1'b0);
    send_step(8'hC3, 1'b1, 1'b1);
  endtask

  // registers changed with a message open: wide to narrow and back
  task automatic test_midmessage_reconfig();
    configure(MODE_FNV1A, 1'b0, '0, 7'd64, 1'b0);
    send_step(8'h5A, 1'b1, 1'b0);
    configure(MODE_FNV1, 1'b0, '0, 7'd8, 1'b0);
    send_step(8'hA5, 1'b1, 1'b1);
    configure(MODE_FNV1A, 1'b0, '0, 7'd16, 1'b0);
    send_step(8'h33, 1'b1, 1'b0);
    configure(MODE_FNV1A, 1'b0, '0, 7'd64, 1'b0);
    send_step(8'hCC, 1'b1, 1'b1);
  endtask

  // receiver holds off long while one-byte messages keep coming,
  // so the pipe fills and in_tready drops
  task automatic test_backpressure();
    configure(MODE_FNV1A, 1'b0, '0, 7'd48, 1'b0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_asked++;
    wait (hold_on);
    for (int i = 0; i < 60; i++) send_step(8'($urandom), 1'b1, 1'b1);
    drain();
  endtask

  // random messages with random settings; mostly short, a few long
  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    int sent;
    int len;
    int steps;
    int pick;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    configure_random();
    while (sent < n_items) begin
      if ($urandom_range(11) == 0) configure_random();
      pick = $urandom_range(9);
      if (pick < 6)      len = $urandom_range(8, 0);
      else if (pick < 9) len = $urandom_range(24, 9);
      else               len = $urandom_range(64, 25);
      send_message(len, ($urandom_range(4) == 0), 1'b1, steps);
      sent += steps;
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_digest();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_modes();
    test_widths();
    test_midmessage_reconfig();
    test_backpressure();
    test_random_traffic(500, 0, 0);
    test_random_traffic(500, 64, 0);
    test_random_traffic(500, 0, 64);
    test_random_traffic(500, 37, 37);

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
